// ===== rtl/core/lambda_token_scanner_macros.svh =====
// Assertion macros for the lambda token scanner.
// Included by the top level; needs a clock and an active-low reset in scope.
`ifndef LAMBDA_TOKEN_SCANNER_MACROS_SVH
`define LAMBDA_TOKEN_SCANNER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lambda token scanner: check failed");

// Next-cycle implication, held off during reset.
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lambda token scanner: check failed");

`endif

// ===== rtl/core/lts_pkg.sv =====
// Shared types for the lambda token scanner.
// Used by lts_scan and lambda_token_scanner; no dependencies.
`default_nettype none

package lts_pkg;

  localparam int unsigned FieldBits = 16;

  typedef enum logic [2:0] {
    KIND_SYMBOL  = 3'd0,
    KIND_BSLASH  = 3'd1,
    KIND_ARROW   = 3'd2,
    KIND_LPAREN  = 3'd3,
    KIND_RPAREN  = 3'd4,
    KIND_EOI     = 3'd5,
    KIND_UNEXPECTED = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    PHASE_IDLE  = 3'b001,
    PHASE_SYM   = 3'b010,
    PHASE_MINUS = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   suppress;
  } ctrl_t;

  typedef struct packed {
    kind_e                kind;
    logic [FieldBits-1:0] start;
    logic [FieldBits-1:0] stop;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/lts_scan.sv =====
// Byte classifier and phase update for the lambda token scanner.
// Pure combinational; depends on lts_pkg.
`default_nettype none

module lts_scan
  import lts_pkg::*;
#(
  parameter int unsigned OffsetBits = 16
) (
  input  logic [7:0]            byte_i,
  input  logic                  eoi_i,
  input  logic [OffsetBits-1:0] pos_i,
  input  logic [OffsetBits-1:0] begin_i,
  input  ctrl_t                 ctrl_i,
  output logic [OffsetBits-1:0] pos_o,
  output logic [OffsetBits-1:0] begin_o,
  output ctrl_t                 ctrl_o,
  output logic [1:0]            count_o,
  output result_t               res0_o,
  output result_t               res1_o
);

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChGt     = 8'h3E;

  localparam logic [OffsetBits-1:0] OffsetMax = '1;

  function automatic logic [OffsetBits-1:0] sat_inc(input logic [OffsetBits-1:0] v);
    return (v == OffsetMax) ? v : v + OffsetBits'(1);
  endfunction

  function automatic result_t mk(input kind_e k, input logic [OffsetBits-1:0] s,
                                 input logic [OffsetBits-1:0] e);
    result_t r;
    r.kind  = k;
    r.start = FieldBits'(s);
    r.stop  = FieldBits'(e);
    r.last  = 1'b0;
    return r;
  endfunction

  logic [OffsetBits-1:0] p_inc, b_inc;
  logic is_letter, is_tail, is_blank;

  assign p_inc = sat_inc(pos_i);
  assign b_inc = sat_inc(begin_i);
  assign is_letter = ((byte_i >= ChLowA) && (byte_i <= ChLowZ)) ||
                     ((byte_i >= ChUpA) && (byte_i <= ChUpZ));
  assign is_tail   = is_letter || ((byte_i >= ChZero) && (byte_i <= ChNine)) ||
                     (byte_i == ChUscore);
  assign is_blank  = (byte_i == ChSpace) || ((byte_i >= ChTab) && (byte_i <= ChCr));

  // Slot a: token flushed from the pending phase. Slot b: token of this byte.
  result_t a, b;
  logic    a_v, b_v, sup, scan_byte;
  phase_e  phase_n;

  always_comb begin
    a         = mk(KIND_SYMBOL, begin_i, pos_i);
    b         = mk(KIND_SYMBOL, pos_i, p_inc);
    a_v       = 1'b0;
    b_v       = 1'b0;
    sup       = ctrl_i.suppress;
    scan_byte = 1'b0;
    phase_n   = ctrl_i.phase;
    pos_o     = p_inc;
    begin_o   = begin_i;

    if (eoi_i) begin
      case (ctrl_i.phase)
        PHASE_SYM: begin
          a_v = 1'b1;
        end
        PHASE_MINUS: begin
          a_v = !sup;
          a   = mk(KIND_UNEXPECTED, begin_i, b_inc);
        end
        default: begin
          a_v = 1'b0;
        end
      endcase
      b_v     = 1'b1;
      b       = mk(KIND_EOI, pos_i, pos_i);
      pos_o   = '0;
      begin_o = '0;
      phase_n = PHASE_IDLE;
      sup     = 1'b0;
    end else begin
      case (ctrl_i.phase)
        PHASE_SYM: begin
          if (!is_tail) begin
            a_v       = 1'b1;
            sup       = 1'b0;
            scan_byte = 1'b1;
          end
        end
        PHASE_MINUS: begin
          if (byte_i == ChGt) begin
            a_v     = 1'b1;
            a       = mk(KIND_ARROW, begin_i, p_inc);
            sup     = 1'b0;
            phase_n = PHASE_IDLE;
          end else begin
            a_v       = !sup;
            a         = mk(KIND_UNEXPECTED, begin_i, b_inc);
            sup       = 1'b1;
            scan_byte = 1'b1;
          end
        end
        default: begin
          scan_byte = 1'b1;
        end
      endcase

      if (scan_byte) begin
        phase_n = PHASE_IDLE;
        if (is_blank) begin
          b_v = 1'b0;
        end else if (is_letter) begin
          begin_o = pos_i;
          phase_n = PHASE_SYM;
        end else if (byte_i == ChBslash) begin
          b_v = 1'b1;
          b   = mk(KIND_BSLASH, pos_i, p_inc);
          sup = 1'b0;
        end else if (byte_i == ChLparen) begin
          b_v = 1'b1;
          b   = mk(KIND_LPAREN, pos_i, p_inc);
          sup = 1'b0;
        end else if (byte_i == ChRparen) begin
          b_v = 1'b1;
          b   = mk(KIND_RPAREN, pos_i, p_inc);
          sup = 1'b0;
        end else if (byte_i == ChMinus) begin
          begin_o = pos_i;
          phase_n = PHASE_MINUS;
        end else begin
          b_v = !sup;
          b   = mk(KIND_UNEXPECTED, pos_i, p_inc);
          sup = 1'b1;
        end
      end
    end

    // Mark the final result of this transaction.
    if (b_v) begin
      b.last = 1'b1;
    end else begin
      a.last = 1'b1;
    end

    ctrl_o.phase    = phase_n;
    ctrl_o.suppress = sup;
    count_o         = {1'b0, a_v} + {1'b0, b_v};
    res0_o          = a_v ? a : b;
    res1_o          = b;
  end

endmodule

`default_nettype wire

// ===== rtl/core/lambda_token_scanner.sv =====
// Lambda token scanner: turns a byte stream into tokens with start and end offsets.
// One source byte is taken per cycle whenever the four-entry result queue has room for
// two results; each byte yields up to two tokens, written to the queue in the same cycle.
// Results leave the queue at one per cycle while the sink is ready, so input then sustains
// one byte per cycle while bytes average at most one token each. No reset sweep; the block
// is ready after reset. Depends on lts_pkg, lts_scan and lambda_token_scanner_macros.svh.
`default_nettype none

`include "lambda_token_scanner_macros.svh"

module lambda_token_scanner
  import lts_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] source_byte
  input  logic        s_axis_tlast_i,   // end_of_input
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [2:0] token_kind, [18:3] token_start,
                                        // [34:19] token_end, [39:35] zero
  output logic        m_axis_tlast_o    // last_result
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrBits = $clog2(QDepth);

  logic [OFFSET_BITS-1:0] pos_q, pos_d, begin_q, begin_d;
  ctrl_t                  ctrl_q, ctrl_d;
  logic [1:0]             n_res;
  result_t                res0, res1;

  logic in_acc, out_acc;

  lts_scan #(
    .OffsetBits(OFFSET_BITS)
  ) u_scan (
    .byte_i (s_axis_tdata_i),
    .eoi_i  (s_axis_tlast_i),
    .pos_i  (pos_q),
    .begin_i(begin_q),
    .ctrl_i (ctrl_q),
    .pos_o  (pos_d),
    .begin_o(begin_d),
    .ctrl_o (ctrl_d),
    .count_o(n_res),
    .res0_o (res0),
    .res1_o (res1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      begin_q <= '0;
      ctrl_q  <= '{phase: PHASE_IDLE, suppress: 1'b0};
    end else if (in_acc) begin
      pos_q   <= pos_d;
      begin_q <= begin_d;
      ctrl_q  <= ctrl_d;
    end
  end

  // Result queue
  result_t            queue_q [QDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]   count_q, count_d;
  logic [1:0]         n_push;
  result_t            head;

  assign s_axis_tready_o = (count_q <= (PtrBits+1)'(QDepth - 2));
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (count_q != '0);
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign n_push          = in_acc ? n_res : 2'd0;
  assign count_d         = count_q + (PtrBits+1)'(n_push) - (PtrBits+1)'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrBits'(n_push);
      rd_ptr_q <= rd_ptr_q + PtrBits'(out_acc);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      queue_q[wr_ptr_q + PtrBits'(1)] <= res1;
    end
  end

  assign head           = queue_q[rd_ptr_q];
  assign m_axis_tdata_o = {5'b0, head.stop, head.start, head.kind};
  assign m_axis_tlast_o = head.last;

  `LTS_ASSERT_NOW(a_queue_bound, clk_i, rst_ni, 1'b1, count_q <= (PtrBits+1)'(QDepth))
  `LTS_ASSERT_NOW(a_eoi_emits, clk_i, rst_ni, in_acc && s_axis_tlast_i,
                  (n_res != 2'd0) && (n_res == 2'd1 ? res0.last : res1.last))
  `LTS_ASSERT_NOW(a_pair_order, clk_i, rst_ni, in_acc && (n_res == 2'd2),
                  !res0.last && res1.last)
  `LTS_ASSERT_NEXT(a_eoi_clears, clk_i, rst_ni, in_acc && s_axis_tlast_i,
                   (pos_q == '0) && (ctrl_q.phase == PHASE_IDLE) && !ctrl_q.suppress)

endmodule

`default_nettype wire
